/* sv/cll_pkg.sv */
package cll_pkg;

  // default pool size and fixed field widths
  localparam int unsigned NODES_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned TOTAL_W   = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_FIRST     = 3'd2;
  localparam logic [OP_W-1:0] OP_NEXT      = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd4;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NO_CURSOR = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic link2;
    logic value_done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic need_link2;
    logic need_value;
  } stat_t;

endpackage

/* sv/circular_list_pool_engine.sv */
// result: loaded in exec for inserts into an empty list, full, error and remove beats;
// in the link2 or value step after exec for inserts into a non-empty list, first, next
// flow: items are taken one at a time, in idle; exec waits for a free result register
// link memory: registered read, single write port (two writes per non-empty insert)
// reset: asynchronous, empties the list, all nodes free, no clearing pass needed
module circular_list_pool_engine #(
  parameter int unsigned NODES = cll_pkg::NODES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [cll_pkg::OP_W-1:0]     op_i,
  input  logic [cll_pkg::DATA_W-1:0]   data_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cll_pkg::STATUS_W-1:0] status_o,
  output logic [cll_pkg::DATA_W-1:0]   data_out_o,
  output logic [cll_pkg::TOTAL_W-1:0]  entry_total_o
);

  cll_pkg::cmd_t  cmd;
  cll_pkg::stat_t stat;

  // sequencer
  cll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // node pool, pointers and result register
  cll_dp #(.NODES(NODES)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op_i),
    .data_in_i     (data_in_i),
    .out_ready_i   (out_ready_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .data_out_o    (data_out_o),
    .entry_total_o (entry_total_o)
  );

endmodule

/* sv/cll_ram.sv */
module cll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/cll_ctrl.sv */
module cll_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cll_pkg::stat_t stat_i,
  output cll_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LINK2,
    S_VALUE
  } state_e;

  state_e state_q, state_d;

  // command decode
  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec       = (state_q == S_EXEC) && stat_i.out_free;
    cmd_o.link2      = (state_q == S_LINK2);
    cmd_o.value_done = (state_q == S_VALUE);
  end

  assign in_ready_o = (state_q == S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          if (stat_i.need_link2) begin
            state_d = S_LINK2;
          end else if (stat_i.need_value) begin
            state_d = S_VALUE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_LINK2: state_d = S_IDLE;
      S_VALUE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/cll_dp.sv */
module cll_dp #(
  parameter int unsigned NODES = cll_pkg::NODES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [cll_pkg::OP_W-1:0]     op_i,
  input  logic [cll_pkg::DATA_W-1:0]   data_in_i,
  input  logic                         out_ready_i,
  input  cll_pkg::cmd_t                cmd_i,
  output cll_pkg::stat_t               stat_o,
  output logic                         out_valid_o,
  output logic [cll_pkg::STATUS_W-1:0] status_o,
  output logic [cll_pkg::DATA_W-1:0]   data_out_o,
  output logic [cll_pkg::TOTAL_W-1:0]  entry_total_o
);

  localparam int unsigned IDX_W = $clog2(NODES);
  localparam int unsigned LVL_W = $clog2(NODES + 1);

  // item registers
  logic [cll_pkg::OP_W-1:0]   op_q;
  logic [cll_pkg::DATA_W-1:0] data_q;

  // list pointers and counters
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [IDX_W-1:0] cursor_q, cursor_d;
  logic [IDX_W-1:0] prev_q, prev_d;
  logic             nonempty_q, nonempty_d;
  logic             cv_q, cv_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic [LVL_W-1:0] low_q, low_d;
  logic [LVL_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] new_q, new_d;
  logic [IDX_W-1:0] head_q, head_d;

  // result register
  logic                         out_valid_q, out_valid_d;
  cll_pkg::status_e             status_q, status_d;
  logic [cll_pkg::DATA_W-1:0]   dout_q, dout_d;
  logic [cll_pkg::TOTAL_W-1:0]  total_q, total_d;

  // memory ports
  logic                       link_we, link_re;
  logic [IDX_W-1:0]           link_waddr, link_wdata, link_raddr, link_rdata;
  logic                       val_we, val_re;
  logic [IDX_W-1:0]           val_waddr, val_raddr;
  logic [cll_pkg::DATA_W-1:0] val_rdata;
  logic                       stk_we;
  logic [IDX_W-1:0]           stk_waddr, stk_wdata, stk_raddr, stk_rdata;

  // decode of the held item
  logic             is_ins, is_first, is_next, is_remove;
  logic             full, fresh, ins_ok, rem_ok, first_ok, next_ok, emptied;
  logic [LVL_W-1:0] level_m1;
  logic [IDX_W-1:0] pop_idx;
  logic             load;

  assign is_ins    = (op_q == cll_pkg::OP_INS_BACK) || (op_q == cll_pkg::OP_INS_FRONT);
  assign is_first  = (op_q == cll_pkg::OP_FIRST);
  assign is_next   = (op_q == cll_pkg::OP_NEXT);
  assign is_remove = (op_q == cll_pkg::OP_REMOVE);

  assign full     = (level_q == '0);
  assign level_m1 = level_q - LVL_W'(1);
  // free stack slots below the low mark were never written and stand for their own index
  assign fresh    = (level_q == low_q);
  assign pop_idx  = fresh ? level_m1[IDX_W-1:0] : stk_rdata;

  assign ins_ok   = is_ins && !full;
  assign first_ok = is_first && nonempty_q;
  assign next_ok  = is_next && nonempty_q && cv_q;
  assign rem_ok   = is_remove && nonempty_q && cv_q;
  assign emptied  = (cursor_q == tail_q) && (link_rdata == cursor_q);

  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.need_link2 = ins_ok && nonempty_q;
  assign stat_o.need_value = first_ok || next_ok;

  assign load = (cmd_i.exec && !stat_o.need_link2 && !stat_o.need_value)
              || cmd_i.link2 || cmd_i.value_done;

  // link memory: read at accept, written in exec and second link step
  assign link_re    = cmd_i.accept;
  assign link_raddr = ((op_i == cll_pkg::OP_NEXT) || (op_i == cll_pkg::OP_REMOVE))
                    ? cursor_q : tail_q;
  assign link_we    = (cmd_i.exec && (ins_ok || rem_ok)) || cmd_i.link2;
  always_comb begin
    if (cmd_i.link2) begin
      link_waddr = new_q;
      link_wdata = head_q;
    end else if (ins_ok) begin
      link_waddr = nonempty_q ? tail_q : pop_idx;
      link_wdata = pop_idx;
    end else begin
      link_waddr = prev_q;
      link_wdata = link_rdata;
    end
  end

  // value memory: cursor read at accept, successor read in exec
  assign val_re    = cmd_i.accept || (cmd_i.exec && stat_o.need_value);
  assign val_raddr = cmd_i.accept ? cursor_q : link_rdata;
  assign val_we    = cmd_i.exec && ins_ok;
  assign val_waddr = pop_idx;

  // free stack: pop read at accept, push in exec
  assign stk_raddr = level_m1[IDX_W-1:0];
  assign stk_we    = cmd_i.exec && rem_ok && (level_q < LVL_W'(NODES));
  assign stk_waddr = level_q[IDX_W-1:0];
  assign stk_wdata = cursor_q;

  cll_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_link (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  cll_ram #(.WIDTH(cll_pkg::DATA_W), .DEPTH(NODES)) u_value (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (data_q),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  cll_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // pointer and counter updates
  always_comb begin
    tail_d     = tail_q;
    cursor_d   = cursor_q;
    prev_d     = prev_q;
    nonempty_d = nonempty_q;
    cv_d       = cv_q;
    level_d    = level_q;
    low_d      = low_q;
    count_d    = count_q;
    new_d      = new_q;
    head_d     = head_q;
    if (cmd_i.exec) begin
      if (ins_ok) begin
        level_d = level_m1;
        low_d   = fresh ? level_m1 : low_q;
        count_d = count_q + LVL_W'(1);
        new_d   = pop_idx;
        // a popped node that is also the tail ends up linked to itself
        head_d  = (pop_idx == tail_q) ? pop_idx : link_rdata;
        if (!nonempty_q || (op_q == cll_pkg::OP_INS_BACK)) begin
          tail_d = pop_idx;
        end
        nonempty_d = 1'b1;
      end
      if (first_ok) begin
        prev_d   = tail_q;
        cursor_d = link_rdata;
        cv_d     = 1'b1;
      end
      if (next_ok) begin
        prev_d   = cursor_q;
        cursor_d = link_rdata;
      end
      if (rem_ok) begin
        cursor_d = prev_q;
        if (cursor_q == tail_q) begin
          tail_d = prev_q;
        end
        if (level_q < LVL_W'(NODES)) begin
          level_d = level_q + LVL_W'(1);
        end
        if (count_q != '0) begin
          count_d = count_q - LVL_W'(1);
        end
        if (emptied) begin
          nonempty_d = 1'b0;
          cv_d       = 1'b0;
          tail_d     = '0;
        end
      end
    end
  end

  // result beat
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    dout_d      = dout_q;
    total_d     = total_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      total_d     = cll_pkg::TOTAL_W'(count_d);
      status_d    = cll_pkg::ST_OK;
      dout_d      = '0;
      if (cmd_i.value_done) begin
        dout_d = val_rdata;
      end else if (cmd_i.exec) begin
        if (is_ins && full) begin
          status_d = cll_pkg::ST_FULL;
        end else if ((is_first || is_next || is_remove) && !nonempty_q) begin
          status_d = cll_pkg::ST_EMPTY;
        end else if ((is_next || is_remove) && !cv_q) begin
          status_d = cll_pkg::ST_NO_CURSOR;
        end else if (rem_ok) begin
          dout_d = val_rdata;
        end
      end
    end
  end

  // item capture, plus the registers without reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_i;
      data_q <= data_in_i;
    end
    new_q   <= new_d;
    head_q  <= head_d;
    dout_q  <= dout_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q      <= '0;
      cursor_q    <= '0;
      prev_q      <= '0;
      nonempty_q  <= 1'b0;
      cv_q        <= 1'b0;
      level_q     <= LVL_W'(NODES);
      low_q       <= LVL_W'(NODES);
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= cll_pkg::ST_OK;
      total_q     <= '0;
    end else begin
      tail_q      <= tail_d;
      cursor_q    <= cursor_d;
      prev_q      <= prev_d;
      nonempty_q  <= nonempty_d;
      cv_q        <= cv_d;
      level_q     <= level_d;
      low_q       <= low_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      total_q     <= total_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign data_out_o    = dout_q;
  assign entry_total_o = total_q;

endmodule
